/* rtl/irm5_pkg.sv */
// Shared types and constants for the raw moment unit.
`default_nettype none
package irm5_pkg;
    localparam int MOMENT_COUNT = 21;
    localparam int ROW_SUM_W = 54;
    localparam int MOM_W = 64;

    // Configuration register indexes.
    localparam logic [0:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;

    // Row-end job handed from the front to the back.
    typedef struct packed {
        logic [5:0][ROW_SUM_W-1:0] sums;
        logic [7:0]                row;
        logic                      frame_end;
    } irm5_job_t;

    function automatic logic [2:0] x_order(input logic [4:0] k);
        logic [2:0] r;
        r = 3'd0;
        unique case (k)
            5'd1, 5'd4, 5'd8, 5'd13, 5'd19: r = 3'd1;
            5'd3, 5'd7, 5'd12, 5'd18:       r = 3'd2;
            5'd6, 5'd11, 5'd17:             r = 3'd3;
            5'd10, 5'd16:                   r = 3'd4;
            5'd15:                          r = 3'd5;
            default:                        r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] y_order(input logic [4:0] k);
        logic [2:0] r;
        r = 3'd0;
        unique case (k)
            5'd2, 5'd4, 5'd7, 5'd11, 5'd16: r = 3'd1;
            5'd5, 5'd8, 5'd12, 5'd17:       r = 3'd2;
            5'd9, 5'd13, 5'd18:             r = 3'd3;
            5'd14, 5'd19:                   r = 3'd4;
            5'd20:                          r = 3'd5;
            default:                        r = 3'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/image_raw_moments_order5_unit.sv */
// Top level of the order-5 raw image moment unit.
// Pixels enter in raster order at up to one per clock within a row. After a row's last
// pixel the input holds off while that row end is in stages 0 to 4 of the six-stage power
// pipeline. Each row end then takes the back end through an accept state, five steps to
// build the powers of y, and a multiply and an add state for each of the 21 moment updates;
// one more row end can wait between front and back, so rows shorter than about 48 pixels
// stall the input. At frame end the 21 moments are popped in order, each beat presented only
// after the one before is popped, and no new row end is taken until the last is popped.
`default_nettype none
module image_raw_moments_order5_unit
    import irm5_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  pixel_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       moment_index,
    output logic [63:0]      moment_value,
    output logic             last_moment,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);
    logic [8:0] width_reg, height_reg;
    logic in_ready, job_valid, job_ready, res_valid;
    irm5_job_t job;

    assign cfg_ready = 1'b1;
    assign full = !in_ready;
    assign empty = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_IMAGE_WIDTH) width_reg <= cfg_data;
            else height_reg <= cfg_data;
        end
    end

    irm5_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_ready(in_ready),
        .pixel(pixel_value), .width_cfg(width_reg), .height_cfg(height_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    irm5_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .res_valid(res_valid), .res_pop(pop), .res_index(moment_index),
        .res_value(moment_value), .res_last(last_moment)
    );
endmodule
`default_nettype wire

/* rtl/irm5_front.sv */
// Front end: pixel power sums per row, column/row tracking, row-end jobs.
`default_nettype none
module irm5_front
    import irm5_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      pixel,
    input  wire logic [8:0]      width_cfg,
    input  wire logic [8:0]      height_cfg,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output irm5_job_t            job
);
    // Pipeline: stage 0 holds pixel and x; p*x^k is computed iteratively across 5 stages.
    // To keep one mult per stage, powers are built over 5 multiplying stages.
    localparam int PW = 48;

    logic [7:0] col_reg, row_reg;
    logic [8:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = (width_cfg == 9'd0) ? 9'd1 :
                (width_cfg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_cfg;
        h_eff = (height_cfg == 9'd0) ? 9'd1 :
                (height_cfg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_cfg;
    end

    // pipe stage s holds term p*x^s
    logic [5:0]          v_reg;
    logic [5:0][PW-1:0]  t_reg;
    logic [5:0][7:0]     x_reg;
    logic [5:0]          re_reg;   // row end
    logic [5:0]          fe_reg;   // frame end
    logic [5:0][7:0]     y_reg;
    logic [5:0][ROW_SUM_W-1:0] s_reg;
    // staggered accumulation: sum k absorbs term at stage k; row end captured at stage 5
    logic [4:0][ROW_SUM_W-1:0] snap_reg; // snapshots of S0..S4 per pipe position

    logic stall;
    logic pipe_busy;
    logic job_load;
    assign stall = job_valid && !job_ready;
    // hold input while a row end is in stages 0 to 4 so sums stay coherent
    assign pipe_busy = |(re_reg[4:0] & v_reg[4:0]);
    assign in_ready = !stall && !pipe_busy;
    assign job_load = !stall && v_reg[5] && re_reg[5];

    logic col_end, row_last;
    assign col_end  = ({1'b0, col_reg} + 9'd1) >= w_eff;
    assign row_last = ({1'b0, row_reg} + 9'd1) >= h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            s_reg <= '0;
            job_valid <= 1'b0;
        end
        else
        begin
            if (job_load)
                job_valid <= 1'b1;
            else if (job_valid && job_ready)
                job_valid <= 1'b0;
            if (!stall)
            begin
                v_reg[0] <= in_valid && in_ready;
                t_reg[0] <= PW'(pixel);
                x_reg[0] <= col_reg;
                re_reg[0] <= col_end;
                fe_reg[0] <= col_end && row_last;
                y_reg[0] <= row_reg;
                if (in_valid && in_ready)
                begin
                    if (col_end)
                    begin
                        col_reg <= '0;
                        row_reg <= row_last ? 8'd0 : row_reg + 8'd1;
                    end
                    else
                        col_reg <= col_reg + 8'd1;
                end
                for (int s = 1; s < 6; s++)
                begin
                    v_reg[s]  <= v_reg[s-1];
                    t_reg[s]  <= PW'(t_reg[s-1] * {{(PW-8){1'b0}}, x_reg[s-1]});
                    x_reg[s]  <= x_reg[s-1];
                    re_reg[s] <= re_reg[s-1];
                    fe_reg[s] <= fe_reg[s-1];
                    y_reg[s]  <= y_reg[s-1];
                end
                // S_k adds term at stage k; at row end stage k the finished S_k is snapped
                for (int s = 0; s < 6; s++)
                begin
                    if (v_reg[s])
                    begin
                        if (re_reg[s])
                            s_reg[s] <= '0;
                        else
                            s_reg[s] <= s_reg[s] + ROW_SUM_W'(t_reg[s]);
                    end
                end
                if (v_reg[0] && re_reg[0]) snap_reg[0] <= s_reg[0] + ROW_SUM_W'(t_reg[0]);
                for (int s = 1; s < 5; s++)
                    if (v_reg[s] && re_reg[s])
                        snap_reg[s] <= s_reg[s] + ROW_SUM_W'(t_reg[s]);
                if (v_reg[5] && re_reg[5])
                begin
                    for (int k = 0; k < 5; k++)
                        job.sums[k] <= snap_reg[k];
                    job.sums[5] <= s_reg[5] + ROW_SUM_W'(t_reg[5]);
                    job.row <= y_reg[5];
                    job.frame_end <= fe_reg[5];
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/irm5_back.sv */
// Back end: folds row sums into moments and streams them out at frame end.
`default_nettype none
module irm5_back
    import irm5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire irm5_job_t   job,
    output logic             res_valid,
    input  wire logic        res_pop,
    output logic [4:0]       res_index,
    output logic [MOM_W-1:0] res_value,
    output logic             res_last
);
    typedef enum logic [2:0] {S_IDLE, S_YPOW, S_MUL, S_ADD, S_EMIT} state_t;
    state_t state_reg;
    irm5_job_t job_reg;
    logic [5:0][39:0] ypow_reg;
    logic [2:0]  yk_reg;
    logic [4:0]  k_reg;
    logic [MOM_W-1:0] pll_reg;
    logic [31:0] pcross_reg;
    logic [MOM_W-1:0] mem [MOMENT_COUNT];
    logic [MOM_W-1:0] rd_reg;

    assign job_ready = (state_reg == S_IDLE);
    assign res_index = k_reg;
    assign res_value = rd_reg;
    assign res_last  = (k_reg == 5'(MOMENT_COUNT - 1));

    // ypow up to 255^5 < 2^40; S up to 2^54. Product mod 2^64 from 32-bit halves:
    // lo*lo in full, cross terms only in their low 32 bits.
    logic [ROW_SUM_W-1:0] sel_s;
    logic [39:0] sel_y;
    logic [31:0] a_lo, b_lo;
    logic [21:0] a_hi;
    logic [7:0]  b_hi;
    always_comb
    begin
        sel_s = job_reg.sums[x_order(k_reg)];
        sel_y = ypow_reg[y_order(k_reg)];
        a_lo = sel_s[31:0];
        a_hi = sel_s[53:32];
        b_lo = sel_y[31:0];
        b_hi = sel_y[39:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            yk_reg <= '0;
            k_reg <= '0;
            res_valid <= 1'b0;
            for (int i = 0; i < MOMENT_COUNT; i++)
                mem[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        ypow_reg[0] <= 40'd1;
                        yk_reg <= 3'd1;
                        state_reg <= S_YPOW;
                    end
                end
                S_YPOW:
                begin
                    ypow_reg[yk_reg] <= 40'(ypow_reg[yk_reg - 3'd1] * {32'd0, job_reg.row});
                    if (yk_reg == 3'd5)
                    begin
                        k_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    yk_reg <= yk_reg + 3'd1;
                end
                S_MUL:
                begin
                    pll_reg <= {32'd0, a_lo} * {32'd0, b_lo};
                    pcross_reg <= a_lo * {24'd0, b_hi} + {10'd0, a_hi} * b_lo;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    mem[k_reg] <= mem[k_reg] + pll_reg + {pcross_reg, 32'd0};
                    if (k_reg == 5'(MOMENT_COUNT - 1))
                    begin
                        k_reg <= '0;
                        state_reg <= job_reg.frame_end ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 5'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_EMIT:
                begin
                    if (!res_valid)
                    begin
                        rd_reg <= mem[k_reg];
                        res_valid <= 1'b1;
                    end
                    else if (res_pop)
                    begin
                        mem[k_reg] <= '0;
                        res_valid <= 1'b0;
                        if (k_reg == 5'(MOMENT_COUNT - 1))
                        begin
                            k_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            k_reg <= k_reg + 5'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/irm5_checker.sv */
// Port-level checks for the raw moment unit.
`default_nettype none
module irm5_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [4:0] moment_index,
    input wire logic       last_moment
);
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> moment_index <= 5'd20) else $error("index out of range");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_moment == (moment_index == 5'd20))) else $error("bad last");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_moment) ##1 !empty |-> moment_index == $past(moment_index) + 5'd1)
        else $error("index skipped");
endmodule

bind image_raw_moments_order5_unit irm5_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .moment_index(moment_index), .last_moment(last_moment)
);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the order-5 raw image moment unit.
`timescale 1ns / 100ps
module tb;
    import irm5_pkg::*;

    localparam int LIMIT = 1000000;
    localparam int SETTLE = 400;
    localparam int WMAX = 256;
    localparam int HMAX = 256;
    localparam bit IDX_WIDTH = REG_IMAGE_WIDTH[0];
    localparam bit IDX_HEIGHT = REG_IMAGE_HEIGHT[0];

    typedef struct {
        logic [4:0]  idx;
        logic [63:0] value;
        logic        last;
    } moment_beat_t;

    typedef struct {
        bit          is_cfg;
        bit          reg_sel;
        logic [8:0]  data;
        bit          typed;
        logic [63:0] m00;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [7:0] pixel_value = '0;
    logic pop = 1'b0;
    logic cfg_valid = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;
    wire full, empty, cfg_ready, last_moment;
    wire [4:0] moment_index;
    wire [63:0] moment_value;

    image_raw_moments_order5_unit uut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .pixel_value(pixel_value),
        .empty(empty), .pop(pop),
        .moment_index(moment_index), .moment_value(moment_value),
        .last_moment(last_moment),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // moment order: x and y exponent of each result
    const int x_pow[21] = '{0,1,0,2,1,0,3,2,1,0,4,3,2,1,0,5,4,3,2,1,0};
    const int y_pow[21] = '{0,0,1,0,1,2,0,1,2,3,0,1,2,3,4,0,1,2,3,4,5};

    logic [8:0]  width_reg, height_reg;
    logic [7:0]  col_pos, row_pos;
    logic [53:0] row_sums [6];
    logic [63:0] moments [21];
    moment_beat_t moment_q [$];

    int errors = 0;
    int cycles = 0;
    int pixels_sent = 0;
    int frames_done = 0;
    int burst_left = 0;
    bit hold_request = 0;

    function automatic int clamp_dim(logic [8:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic accumulate_pixel(input logic [7:0] p);
        logic [63:0] term;
        logic [63:0] ypow [6];
        moment_beat_t b;
        int w, h, k;
        w = clamp_dim(width_reg, WMAX);
        h = clamp_dim(height_reg, HMAX);
        term = {56'd0, p};
        for (k = 0; k < 6; k++)
        begin
            row_sums[k] = row_sums[k] + term[53:0];
            term = term * {56'd0, col_pos};
        end
        if (col_pos + 1 < w)
        begin
            col_pos = col_pos + 8'd1;
            return;
        end
        ypow[0] = 64'd1;
        for (k = 1; k < 6; k++)
            ypow[k] = ypow[k-1] * {56'd0, row_pos};
        for (k = 0; k < 21; k++)
            moments[k] = moments[k] + {10'd0, row_sums[x_pow[k]]} * ypow[y_pow[k]];
        for (k = 0; k < 6; k++)
            row_sums[k] = '0;
        col_pos = '0;
        if (row_pos + 1 < h)
        begin
            row_pos = row_pos + 8'd1;
            return;
        end
        for (k = 0; k < 21; k++)
        begin
            b.idx = k[4:0];
            b.value = moments[k];
            b.last = (k == 20);
            moment_q.push_back(b);
            moments[k] = '0;
        end
        row_pos = '0;
        frames_done++;
    endtask

    // block must be drained before any register write
    task automatic write_reg(input bit sel, input logic [8:0] v);
        push <= 1'b0;
        while (moment_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == IDX_WIDTH)
            width_reg = v;
        else
            height_reg = v;
        burst_left = 0;
    endtask

    task automatic send_pixel(input logic [7:0] p);
        int g;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                g = $urandom_range(1, 6);
                push <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        pixel_value <= p;
        do
            @(posedge clk);
        while (full);
        accumulate_pixel(p);
        pixels_sent++;
    endtask

    // result side: random pop pattern plus one long hold-off
    int pop_mode = 0;
    int hold_left = 0;
    bit hold_done = 0;
    moment_beat_t want;
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (moment_q.size() == 0)
            begin
                $error("unexpected moment beat idx=%0d", moment_index);
                errors++;
            end
            else
            begin
                want = moment_q.pop_front();
                if (moment_index !== want.idx)
                begin
                    $error("moment_index exp %0d got %0d", want.idx, moment_index);
                    errors++;
                end
                if (moment_value !== want.value)
                begin
                    $error("moment_value exp %0d got %0d", want.value, moment_value);
                    errors++;
                end
                if (last_moment !== want.last)
                begin
                    $error("last_moment exp %0d got %0d", want.last, last_moment);
                    errors++;
                end
            end
        end
        if (hold_request && !hold_done)
        begin
            hold_done = 1;
            hold_left = 3000;
        end
        if (cycles % 64 == 0)
            pop_mode = $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_mode == 0)
            pop <= 1'b1;
        else if (pop_mode == 1)
            pop <= 1'($urandom_range(0, 1));
        else
            pop <= ($urandom_range(0, 4) == 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    stim_row_t plan [$];

    function automatic stim_row_t cfg_row(bit sel, logic [8:0] v);
        stim_row_t r;
        r = '{1'b1, sel, v, 1'b0, 64'd0};
        return r;
    endfunction

    function automatic stim_row_t pix_row(logic [7:0] p, bit typed, logic [63:0] m);
        stim_row_t r;
        r = '{1'b0, 1'b0, {1'b0, p}, typed, m};
        return r;
    endfunction

    initial
    begin
        int i, k, n, w, h, ph, small_items, base;
        width_reg = 9'd256;
        height_reg = 9'd256;
        col_pos = '0;
        row_pos = '0;
        for (k = 0; k < 6; k++) row_sums[k] = '0;
        for (k = 0; k < 21; k++) moments[k] = '0;

        // 1x1 frames: only m00 can be nonzero
        plan.push_back(cfg_row(IDX_WIDTH, 9'd1));
        plan.push_back(cfg_row(IDX_HEIGHT, 9'd1));
        plan.push_back(pix_row(8'd0, 1, 64'd0));
        plan.push_back(pix_row(8'd255, 1, 64'd255));
        plan.push_back(pix_row(8'd1, 1, 64'd1));
        // zero size acts as one
        plan.push_back(cfg_row(IDX_WIDTH, 9'd0));
        plan.push_back(cfg_row(IDX_HEIGHT, 9'd0));
        plan.push_back(pix_row(8'd128, 1, 64'd128));
        plan.push_back(cfg_row(IDX_WIDTH, 9'd3));
        plan.push_back(cfg_row(IDX_HEIGHT, 9'd2));
        for (i = 0; i < 6; i++) plan.push_back(pix_row(8'd255, 0, 0));
        // size shrunk mid-frame: counters already past the new end
        plan.push_back(cfg_row(IDX_WIDTH, 9'd4));
        plan.push_back(cfg_row(IDX_HEIGHT, 9'd3));
        for (i = 0; i < 7; i++) plan.push_back(pix_row(8'(i * 37 + 11), 0, 0));
        plan.push_back(cfg_row(IDX_WIDTH, 9'd2));
        plan.push_back(pix_row(8'd200, 0, 0));
        plan.push_back(cfg_row(IDX_HEIGHT, 9'd1));
        plan.push_back(pix_row(8'd90, 0, 0));
        plan.push_back(pix_row(8'd170, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[j])
        begin
            if (plan[j].is_cfg)
                write_reg(plan[j].reg_sel, plan[j].data);
            else
            begin
                send_pixel(plan[j].data[7:0]);
                if (plan[j].typed)
                begin
                    base = moment_q.size() - 21;
                    for (k = 0; k < 21; k++)
                        moment_q[base + k].value = (k == 0) ? plan[j].m00 : 64'd0;
                end
            end
        end

        // pile up 1x1 frames while the receiver holds off
        write_reg(IDX_WIDTH, 9'd1);
        write_reg(IDX_HEIGHT, 9'd1);
        hold_request = 1;
        for (i = 0; i < 30; i++)
            send_pixel(8'($urandom_range(0, 255)));

        small_items = 0;
        ph = 0;
        while (small_items < 40 || ph < 6)
        begin
            if (ph == 2)
            begin
                w = 511; h = 1;
            end
            else if (ph == 5)
            begin
                w = 1; h = 300;
            end
            else
            begin
                k = $urandom_range(0, 9);
                w = (k == 0) ? 0 : (k < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
                k = $urandom_range(0, 9);
                h = (k == 0) ? 0 : $urandom_range(1, 5);
            end
            write_reg(IDX_WIDTH, w[8:0]);
            write_reg(IDX_HEIGHT, h[8:0]);
            n = clamp_dim(w[8:0], WMAX) * clamp_dim(h[8:0], HMAX);
            if (ph == 5)
                n = 40;
            else if (ph != 2)
            begin
                n = n * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0)
                    n = n + $urandom_range(1, 5);
                small_items += n;
            end
            for (i = 0; i < n; i++)
                send_pixel(($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
            ph++;
        end
        // finish any partial frame
        write_reg(IDX_HEIGHT, 9'd1);
        write_reg(IDX_WIDTH, 9'd1);
        send_pixel(8'($urandom_range(0, 255)));

        push <= 1'b0;
        while (moment_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d pixels, %0d frames: sizes 1x1 up to a clamped 256-wide row, a tall",
                 pixels_sent, frames_done);
        $display("partial frame, mid-frame resizes and a long result stall; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* image_raw_moments_order5_unit.f */
rtl/irm5_pkg.sv
rtl/irm5_front.sv
rtl/irm5_back.sv
rtl/image_raw_moments_order5_unit.sv
rtl/irm5_checker.sv
verif/tb.sv
